[design/range_min_segment_tree_defines.svh]
// Assertion helpers for the range minimum segment tree.
// Both forms use the clock clk and the active-low reset rst_n of the calling module.
`ifndef RANGE_MIN_SEGMENT_TREE_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define RMST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMST_ASSERT_SAME(lbl, ante, cons, msg)
`define RMST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[design/rmst_pkg.sv]
package rmst_pkg;

  // Field widths.
  localparam int VALUE_W = 30;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;

  // Default tree size and register reset.
  localparam int LEAF_COUNT_DEF   = 1024;
  localparam int USED_COUNT_RESET = 1024;

  // Value of an empty range and of every node after reset.
  localparam logic [VALUE_W-1:0] NEUTRAL_VALUE = VALUE_W'(1000000000);

  // Request kinds.
  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_LOAD_LEAF,
    S_LOAD_UP,
    S_Q_RUN,
    S_Q_DRAIN,
    S_Q_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic setup;
    logic clear;
    logic load_start;
    logic load_step;
    logic q_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic idx_ok;
    logic range_empty;
    logic load_last;
    logic q_last;
    logic out_busy;
  } status_t;

  function automatic logic [VALUE_W-1:0] min_value(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[design/rmst_ctrl.sv]
module rmst_ctrl
  import rmst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status_i,
  output logic    in_stall,
  output cmd_t    cmd_o
);

  state_t state_r;
  state_t state_nxt;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        if (status_i.is_query) begin
          state_nxt = status_i.range_empty ? S_Q_OUT : S_Q_RUN;
        end else begin
          state_nxt = status_i.idx_ok ? S_LOAD_LEAF : S_IDLE;
        end
      end
      S_LOAD_LEAF: begin
        cmd_o.load_start = 1'b1;
        state_nxt        = S_LOAD_UP;
      end
      S_LOAD_UP: begin
        cmd_o.load_step = 1'b1;
        if (status_i.load_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_RUN: begin
        cmd_o.q_step = 1'b1;
        if (status_i.q_last) begin
          state_nxt = S_Q_DRAIN;
        end
      end
      S_Q_DRAIN: begin
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

[design/rmst_datapath.sv]
`include "range_min_segment_tree_defines.svh"

module rmst_datapath
  import rmst_pkg::*;
#(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_used_count,
  input  logic               in_action,
  input  logic [IDX_W-1:0]   in_leaf_index,
  input  logic [VALUE_W-1:0] in_leaf_value,
  input  logic [IDX_W-1:0]   in_range_low,
  input  logic [IDX_W-1:0]   in_range_high,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_range_minimum,
  input  cmd_t               cmd_i,
  output status_t            status_o
);

  // Node address width, a wider position for the right bound, and a compare width.
  localparam int DEPTH = 2 * LEAF_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;
  localparam int CW    = (PW > CNT_W) ? PW : CNT_W;
  localparam logic [CW-1:0] USED_RESET =
    (USED_COUNT_RESET > LEAF_COUNT) ? CW'(LEAF_COUNT) : CW'(USED_COUNT_RESET);

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [CW-1:0]      used_sat_r;
  logic [CW-1:0]      used_m1_r;
  logic [CW-1:0]      cfg_sat;
  logic               act_r;
  logic [IDX_W-1:0]   idx_r;
  logic [VALUE_W-1:0] val_r;
  logic [IDX_W-1:0]   lo_r;
  logic [IDX_W-1:0]   hi_r;
  logic [AW-1:0]      clr_r;
  logic [AW-1:0]      pos_r;
  logic [VALUE_W-1:0] cur_r;
  logic [PW-1:0]      left_r;
  logic [PW-1:0]      right_r;
  logic               take_a_r;
  logic               take_b_r;
  logic [VALUE_W-1:0] rd_a_r;
  logic [VALUE_W-1:0] rd_b_r;
  logic [VALUE_W-1:0] best_r;
  logic [VALUE_W-1:0] best_nxt;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_data_r;

  logic [CW-1:0]      high_c;
  logic [PW-1:0]      leaf_pos;
  logic [AW-1:0]      parent;
  logic [VALUE_W-1:0] cur_nxt;
  logic [PW-1:0]      left_step;
  logic [PW-1:0]      right_step;
  logic [PW-1:0]      right_dec;
  logic [VALUE_W-1:0] sel_a;
  logic [VALUE_W-1:0] sel_b;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      raddr_a;
  logic [AW-1:0]      raddr_b;

  // Leaf count register, kept saturated to the tree size.
  assign cfg_sat = (CW'(cfg_used_count) > CW'(LEAF_COUNT)) ? CW'(LEAF_COUNT)
                                                           : CW'(cfg_used_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_sat_r <= USED_RESET;
      used_m1_r  <= USED_RESET - CW'(1);
    end else if (cfg_wr_en) begin
      used_sat_r <= cfg_sat;
      used_m1_r  <= cfg_sat - CW'(1);
    end
  end

  // Capture the request; load values above the neutral value saturate.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      act_r <= in_action;
      idx_r <= in_leaf_index;
      val_r <= (in_leaf_value > NEUTRAL_VALUE) ? NEUTRAL_VALUE : in_leaf_value;
      lo_r  <= in_range_low;
      hi_r  <= in_range_high;
    end
  end

  // Request checks and range clipping.
  assign high_c   = (CW'(hi_r) > used_m1_r) ? used_m1_r : CW'(hi_r);
  assign leaf_pos = PW'(idx_r) + PW'(LEAF_COUNT);

  // Load walk: one level per cycle, with the sibling read in the cycle before.
  assign parent  = pos_r >> 1;
  assign cur_nxt = min_value(cur_r, rd_a_r);

  // Query walk: both bounds move up one level per cycle.
  assign left_step  = (left_r + PW'(left_r[0])) >> 1;
  assign right_step = (right_r - PW'(right_r[0])) >> 1;
  assign right_dec  = right_r - PW'(1);

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = NEUTRAL_VALUE;
    raddr_a   = left_r[AW-1:0];
    raddr_b   = right_dec[AW-1:0];
    if (cmd_i.clear) begin
      mem_we = 1'b1;
    end else if (cmd_i.load_start) begin
      mem_we    = 1'b1;
      mem_waddr = leaf_pos[AW-1:0];
      mem_wdata = val_r;
      raddr_a   = leaf_pos[AW-1:0] ^ AW'(1);
    end else if (cmd_i.load_step) begin
      mem_we    = 1'b1;
      mem_waddr = parent;
      mem_wdata = cur_nxt;
      raddr_a   = parent ^ AW'(1);
    end
  end

  // Tree storage with registered reads.
  always_ff @(posedge clk) begin
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd_i.clear) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // Load position and running minimum.
  always_ff @(posedge clk) begin
    if (cmd_i.load_start) begin
      pos_r <= leaf_pos[AW-1:0];
      cur_r <= val_r;
    end else if (cmd_i.load_step) begin
      pos_r <= parent;
      cur_r <= cur_nxt;
    end
  end

  // Query bounds.
  always_ff @(posedge clk) begin
    if (cmd_i.setup) begin
      left_r  <= PW'(lo_r) + PW'(LEAF_COUNT);
      right_r <= PW'(high_c) + PW'(LEAF_COUNT) + PW'(1);
    end else if (cmd_i.q_step) begin
      left_r  <= left_step;
      right_r <= right_step;
    end
  end

  // Flags that mark which read data joins the minimum next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_a_r <= 1'b0;
      take_b_r <= 1'b0;
    end else begin
      take_a_r <= cmd_i.q_step & left_r[0];
      take_b_r <= cmd_i.q_step & right_r[0];
    end
  end

  // Query minimum accumulator.
  assign sel_a = take_a_r ? rd_a_r : NEUTRAL_VALUE;
  assign sel_b = take_b_r ? rd_b_r : NEUTRAL_VALUE;

  always_comb begin
    best_nxt = min_value(best_r, min_value(sel_a, sel_b));
    if (cmd_i.setup) begin
      best_nxt = NEUTRAL_VALUE;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  // Output register; a waiting result holds until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      out_data_r <= best_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_range_minimum = out_data_r;

  // Status back to the controller.
  always_comb begin
    status_o             = '0;
    status_o.clear_last  = (clr_r == AW'(DEPTH - 1));
    status_o.is_query    = (act_r == ACTION_QUERY);
    status_o.idx_ok      = (CW'(idx_r) < used_sat_r);
    status_o.range_empty = (used_sat_r == '0) || (CW'(lo_r) > high_c);
    status_o.load_last   = (parent == AW'(1));
    status_o.q_last      = !(left_step < right_step);
    status_o.out_busy    = out_valid_r & out_stall;
  end

  `RMST_ASSERT_SAME(a_load_above_root, cmd_i.load_step, pos_r > AW'(1), "load walked past the root")
  `RMST_ASSERT_SAME(a_query_bounds, cmd_i.q_step, left_r < right_r, "query step with empty span")
  `RMST_ASSERT_SAME(a_take_after_step, take_a_r || take_b_r, $past(cmd_i.q_step), "stray read take")
  `RMST_ASSERT_SAME(a_result_range, out_valid_r, out_data_r <= NEUTRAL_VALUE, "result out of range")

endmodule

[design/range_min_segment_tree.sv]
// Range minimum segment tree over LEAF_COUNT leaves of 30-bit values. A load request
// (action 0) stores a value, saturated to 1000000000, at one leaf below used_count and
// refreshes every ancestor; it gives no result. A query request (action 1) returns the
// minimum over the leaves in use between range_low and range_high inclusive, or
// 1000000000 if that range is empty. One request is worked on at a time; the tree
// memory, with one write and two read ports, is touched once per tree level. A load
// passes from acceptance through setup, a leaf write and one parent write per level
// up to the root, or returns to idle after setup when its leaf is not in use; a query
// passes through setup, one walk step per level climbed before its bounds meet, a
// drain state and the output state, or from setup straight to output for an empty
// range, and may wait there for the output register to be taken. A query may be
// accepted while the previous result still waits in the output register. After reset
// the block clears all 2*LEAF_COUNT nodes and holds in_stall high meanwhile; writes
// to used_count are taken at any time but should be made only while the block is idle.
module range_min_segment_tree
  import rmst_pkg::*;
#(
  parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CNT_W-1:0]   cfg_used_count,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [IDX_W-1:0]   in_leaf_index,
  input  logic [VALUE_W-1:0] in_leaf_value,
  input  logic [IDX_W-1:0]   in_range_low,
  input  logic [IDX_W-1:0]   in_range_high,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_range_minimum
);

  cmd_t    cmd;
  status_t status;

  // Sequencer for clearing, loads and queries.
  rmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status_i (status),
    .in_stall (in_stall),
    .cmd_o    (cmd)
  );

  // Tree memory, walk registers and output register.
  rmst_datapath #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_used_count    (cfg_used_count),
    .in_action         (in_action),
    .in_leaf_index     (in_leaf_index),
    .in_leaf_value     (in_leaf_value),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_range_minimum (out_range_minimum),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule
